// ----- rtl/core/pbcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbcc_pkg
// Shared types and constants of the pileup base call counter: the call and
// count payload structs, the class codes and the decoder result.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcc_pkg;

	// Counter width and saturation value
	localparam int unsigned COUNT_WIDTH = 16;
	localparam int unsigned NUM_CLASSES = 11;
	localparam int unsigned CLS_WIDTH   = 4;
	localparam int unsigned MINQ_WIDTH  = 7;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// Sanger quality offset
	localparam logic [8:0] SANGER_OFFSET = 9'd33;

	// Special call characters
	localparam logic [7:0] CH_FWD_REF   = 8'h2E; // '.'
	localparam logic [7:0] CH_REV_REF   = 8'h2C; // ','
	localparam logic [7:0] CH_READ_END  = 8'h24; // '$'
	localparam logic [7:0] CH_READ_BEG  = 8'h5E; // '^'
	localparam logic [7:0] CH_DELETION  = 8'h2A; // '*'
	localparam logic [7:0] CH_FWD_A     = 8'h41;
	localparam logic [7:0] CH_FWD_C     = 8'h43;
	localparam logic [7:0] CH_FWD_G     = 8'h47;
	localparam logic [7:0] CH_FWD_T     = 8'h54;
	localparam logic [7:0] CH_FWD_N     = 8'h4E;
	localparam logic [7:0] CH_REV_A     = 8'h61;
	localparam logic [7:0] CH_REV_C     = 8'h63;
	localparam logic [7:0] CH_REV_G     = 8'h67;
	localparam logic [7:0] CH_REV_T     = 8'h74;
	localparam logic [7:0] CH_REV_N     = 8'h6E;

	// Reference base codes; anything above REF_N means "other"
	localparam logic [2:0] REF_N = 3'd4;

	// Class codes
	localparam logic [CLS_WIDTH-1:0] CLS_FWD_A    = 4'd0;
	localparam logic [CLS_WIDTH-1:0] CLS_FWD_C    = 4'd1;
	localparam logic [CLS_WIDTH-1:0] CLS_FWD_G    = 4'd2;
	localparam logic [CLS_WIDTH-1:0] CLS_FWD_T    = 4'd3;
	localparam logic [CLS_WIDTH-1:0] CLS_FWD_N    = 4'd4;
	localparam logic [CLS_WIDTH-1:0] CLS_DELETION = 4'd5;
	localparam logic [CLS_WIDTH-1:0] CLS_REV_A    = 4'd6;
	localparam logic [CLS_WIDTH-1:0] CLS_REV_C    = 4'd7;
	localparam logic [CLS_WIDTH-1:0] CLS_REV_G    = 4'd8;
	localparam logic [CLS_WIDTH-1:0] CLS_REV_T    = 4'd9;
	localparam logic [CLS_WIDTH-1:0] CLS_REV_N    = 4'd10;

	// One call byte of a site
	typedef struct packed {
		logic [7:0] call_char;
		logic [7:0] qual_char;
		logic [2:0] ref_base;
		logic       site_last;
	} pbcc_call_t;

	// Counts of one site
	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count_fwd_a;
		logic [COUNT_WIDTH-1:0] count_fwd_c;
		logic [COUNT_WIDTH-1:0] count_fwd_g;
		logic [COUNT_WIDTH-1:0] count_fwd_t;
		logic [COUNT_WIDTH-1:0] count_fwd_n;
		logic [COUNT_WIDTH-1:0] count_deletion;
		logic [COUNT_WIDTH-1:0] count_rev_a;
		logic [COUNT_WIDTH-1:0] count_rev_c;
		logic [COUNT_WIDTH-1:0] count_rev_g;
		logic [COUNT_WIDTH-1:0] count_rev_t;
		logic [COUNT_WIDTH-1:0] count_rev_n;
	} pbcc_counts_t;

	// Decoder result for one call byte
	typedef struct packed {
		logic                 hit;       // bump the class counter
		logic [CLS_WIDTH-1:0] cls;       // class to bump
		logic                 skip_next; // next byte is a mapping quality
	} pbcc_decode_t;

endpackage

`default_nettype wire

// ----- rtl/core/pbcc_classify.sv -----
// ----------------------------------------------------------------------------
// pbcc_classify
// Decodes one call byte: read marks, mapping-quality skip, quality threshold
// and class selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcc_classify (
	input  wire pbcc_pkg::pbcc_call_t   call,
	input  wire                         skip,
	input  wire [6:0]                   min_quality,
	output pbcc_pkg::pbcc_decode_t      dec
);
	import pbcc_pkg::*;

	logic                 cls_ok;
	logic [CLS_WIDTH-1:0] cls;
	logic                 qual_ok;

	// Map the call byte to a class
	always_comb begin
		cls_ok = 1'b1;
		cls    = CLS_FWD_A;
		case (call.call_char)
			CH_FWD_A:    cls = CLS_FWD_A;
			CH_FWD_C:    cls = CLS_FWD_C;
			CH_FWD_G:    cls = CLS_FWD_G;
			CH_FWD_T:    cls = CLS_FWD_T;
			CH_FWD_N:    cls = CLS_FWD_N;
			CH_DELETION: cls = CLS_DELETION;
			CH_REV_A:    cls = CLS_REV_A;
			CH_REV_C:    cls = CLS_REV_C;
			CH_REV_G:    cls = CLS_REV_G;
			CH_REV_T:    cls = CLS_REV_T;
			CH_REV_N:    cls = CLS_REV_N;
			CH_FWD_REF: begin
				cls_ok = (call.ref_base <= REF_N);
				cls    = {1'b0, call.ref_base};
			end
			CH_REV_REF: begin
				cls_ok = (call.ref_base <= REF_N);
				cls    = CLS_REV_A + {1'b0, call.ref_base};
			end
			default: cls_ok = 1'b0;
		endcase
	end

	// Compare the Sanger quality against the threshold
	assign qual_ok = {1'b0, call.qual_char} >= (SANGER_OFFSET + {2'b00, min_quality});

	// Apply the read marks and the mapping-quality skip
	always_comb begin
		dec.cls       = cls;
		dec.hit       = 1'b0;
		dec.skip_next = 1'b0;
		if (skip) begin
			dec.skip_next = 1'b0;
		end else if (call.call_char == CH_READ_BEG) begin
			dec.skip_next = 1'b1;
		end else if (call.call_char != CH_READ_END) begin
			dec.hit = cls_ok && qual_ok;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pileup_base_call_counter_unit.sv -----
// ----------------------------------------------------------------------------
// pileup_base_call_counter_unit
// Counts the base calls of pileup sites into 11 saturating class counters and
// hands out all counts on the last call byte of each site.
// ----------------------------------------------------------------------------
// The block takes one call byte per cycle unless the input register is held.
// A byte is held in an input register, where it is decoded and its class
// counter bumped; on a site-end byte the updated counts go into the result
// register and the counters clear, so a site's counts reach the count channel
// through the result register. Only a site-end byte meeting a result register
// that is still full holds the input register, and with it the call channel;
// every other byte flows on at one per cycle. min_quality may be written only
// while no byte is in flight.
`default_nettype none

module pileup_base_call_counter_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration write
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [6:0]                    cfg_data,
	// Call bytes
	input  wire                          call_valid,
	output logic                         call_ready,
	input  wire pbcc_pkg::pbcc_call_t    call,
	// Site counts
	output logic                         count_valid,
	input  wire                          count_ready,
	output pbcc_pkg::pbcc_counts_t       counts
);
	import pbcc_pkg::*;

	logic [MINQ_WIDTH-1:0]  min_quality_q;
	logic                   valid_s1;
	pbcc_call_t             call_s1;
	logic                   skip_q;
	logic [COUNT_WIDTH-1:0] cnt_q    [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] cnt_next [NUM_CLASSES];
	pbcc_decode_t           dec;
	logic                   out_free;
	logic                   adv_s1;
	logic                   load_out;
	logic                   out_valid_q;
	pbcc_counts_t           counts_q;
	logic                   cnt_zero;

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_quality_q <= '0;
		end else if (cfg_valid) begin
			min_quality_q <= cfg_data;
		end
	end

	// Advance the held byte unless it ends a site and the result slot is full
	assign out_free   = !out_valid_q || count_ready;
	assign adv_s1     = valid_s1 && (!call_s1.site_last || out_free);
	assign load_out   = adv_s1 && call_s1.site_last;
	assign call_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (call_ready) begin
			valid_s1 <= call_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (call_ready && call_valid) begin
			call_s1 <= call;
		end
	end

	// Decode the held byte
	pbcc_classify u_classify (
		.call        (call_s1),
		.skip        (skip_q),
		.min_quality (min_quality_q),
		.dec         (dec)
	);

	// Bump the selected counter, holding it at its maximum
	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			cnt_next[i] = cnt_q[i];
			if (dec.hit && dec.cls == CLS_WIDTH'(i) && cnt_q[i] != COUNT_MAX) begin
				cnt_next[i] = cnt_q[i] + COUNT_WIDTH'(1);
			end
		end
	end

	// Counters and skip flag: clear at site end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (adv_s1) begin
			skip_q <= call_s1.site_last ? 1'b0 : dec.skip_next;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= call_s1.site_last ? '0 : cnt_next[i];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (count_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			counts_q.count_fwd_a    <= cnt_next[CLS_FWD_A];
			counts_q.count_fwd_c    <= cnt_next[CLS_FWD_C];
			counts_q.count_fwd_g    <= cnt_next[CLS_FWD_G];
			counts_q.count_fwd_t    <= cnt_next[CLS_FWD_T];
			counts_q.count_fwd_n    <= cnt_next[CLS_FWD_N];
			counts_q.count_deletion <= cnt_next[CLS_DELETION];
			counts_q.count_rev_a    <= cnt_next[CLS_REV_A];
			counts_q.count_rev_c    <= cnt_next[CLS_REV_C];
			counts_q.count_rev_g    <= cnt_next[CLS_REV_G];
			counts_q.count_rev_t    <= cnt_next[CLS_REV_T];
			counts_q.count_rev_n    <= cnt_next[CLS_REV_N];
		end
	end

	assign count_valid = out_valid_q;
	assign counts      = counts_q;

	// All counters at zero
	always_comb begin
		cnt_zero = 1'b1;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (cnt_q[i] != '0) begin
				cnt_zero = 1'b0;
			end
		end
	end

	// A site end leaves clean counters and no pending skip
	a_site_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (cnt_zero && !skip_q))
		else $error("counters or skip flag not cleared after site end");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || count_ready))
		else $error("result register overwritten");

	// A stalled input byte stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(call_s1)))
		else $error("held call byte lost");

	// A stall only happens on a site end with a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (call_s1.site_last && out_valid_q && !count_ready))
		else $error("unexpected stall");

endmodule

`default_nettype wire

// ----- tb/pileup_base_call_counter_checker.sv -----
// ----------------------------------------------------------------------------
// pileup_base_call_counter_checker
// Watches the configuration, call and count channels of the pileup base call
// counter. Keeps its own copy of the class tallies, the mapping-quality skip
// flag and min_quality. Builds the expected counts of every site on its last
// call byte and compares each count transfer field by field against the
// oldest one still due.
// ----------------------------------------------------------------------------
module pileup_base_call_counter_checker
	import pbcc_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	input  wire                cfg_ready,
	input  wire [6:0]          cfg_data,
	input  wire                call_valid,
	input  wire                call_ready,
	input  wire pbcc_call_t    call,
	input  wire                count_valid,
	input  wire                count_ready,
	input  wire pbcc_counts_t  counts,
	output int unsigned        mismatch_count,
	output int unsigned        sites_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NO_CLASS = -1;

	typedef logic [NUM_CLASSES*COUNT_WIDTH-1:0] count_row_t;

	logic [COUNT_WIDTH-1:0] class_tally [NUM_CLASSES];
	logic                   mapq_next;
	logic [MINQ_WIDTH-1:0]  min_qual;
	count_row_t             counts_due [$];

	string class_name [NUM_CLASSES] = '{
		"count_fwd_a", "count_fwd_c", "count_fwd_g", "count_fwd_t", "count_fwd_n",
		"count_deletion",
		"count_rev_a", "count_rev_c", "count_rev_g", "count_rev_t", "count_rev_n"
	};

	// Class of a call byte at the given reference, or NO_CLASS
	function automatic int call_class(input logic [7:0] c, input logic [2:0] ref_code);
		case (c)
			CH_FWD_A:    return int'(CLS_FWD_A);
			CH_FWD_C:    return int'(CLS_FWD_C);
			CH_FWD_G:    return int'(CLS_FWD_G);
			CH_FWD_T:    return int'(CLS_FWD_T);
			CH_FWD_N:    return int'(CLS_FWD_N);
			CH_DELETION: return int'(CLS_DELETION);
			CH_REV_A:    return int'(CLS_REV_A);
			CH_REV_C:    return int'(CLS_REV_C);
			CH_REV_G:    return int'(CLS_REV_G);
			CH_REV_T:    return int'(CLS_REV_T);
			CH_REV_N:    return int'(CLS_REV_N);
			CH_FWD_REF:  return (ref_code <= REF_N) ? int'(ref_code) : NO_CLASS;
			CH_REV_REF:  return (ref_code <= REF_N) ? int'(CLS_REV_A) + int'(ref_code) : NO_CLASS;
			default:     return NO_CLASS;
		endcase
	endfunction

	// Advance the tallies by one call byte; on a site end queue its counts and clear
	task automatic tally_call(input pbcc_call_t b);
		int         cls;
		count_row_t row;
		cls = call_class(b.call_char, b.ref_base);
		if (mapq_next) begin
			// mapping-quality byte after a read start: drop whatever it is
			mapq_next = 1'b0;
		end else if (b.call_char == CH_READ_BEG) begin
			mapq_next = 1'b1;
		end else if (b.call_char != CH_READ_END && cls != NO_CLASS
				&& {1'b0, b.qual_char} >= SANGER_OFFSET + {2'b00, min_qual}) begin
			// saturate at the counter maximum
			if (class_tally[cls] != COUNT_MAX)
				class_tally[cls]++;
		end
		if (b.site_last) begin
			for (int i = 0; i < NUM_CLASSES; i++)
				row[(NUM_CLASSES-1-i)*COUNT_WIDTH +: COUNT_WIDTH] = class_tally[i];
			counts_due.push_back(row);
			foreach (class_tally[i])
				class_tally[i] = '0;
			mapq_next = 1'b0;
		end
	endtask

	// Compare one count transfer with the oldest site still due
	task automatic check_counts(input count_row_t got);
		count_row_t want;
		if (counts_due.size() == 0) begin
			$display("%0t ns: count transfer with no site due, got %h", $time, got);
			mismatch_count++;
		end else begin
			want = counts_due.pop_front();
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (got[(NUM_CLASSES-1-i)*COUNT_WIDTH +: COUNT_WIDTH]
						!== want[(NUM_CLASSES-1-i)*COUNT_WIDTH +: COUNT_WIDTH]) begin
					$display("%0t ns: %s expected %0d, got %0d", $time, class_name[i],
						want[(NUM_CLASSES-1-i)*COUNT_WIDTH +: COUNT_WIDTH],
						got[(NUM_CLASSES-1-i)*COUNT_WIDTH +: COUNT_WIDTH]);
					mismatch_count++;
				end
			end
		end
	endtask

	// Follow every transfer; results are checked before a new site is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (class_tally[i])
				class_tally[i] = '0;
			mapq_next = 1'b0;
			min_qual = '0;
			counts_due.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_qual = cfg_data;
			if (count_valid && count_ready)
				check_counts(counts);
			if (call_valid && call_ready)
				tally_call(call);
		end
		sites_due = counts_due.size();
	end

endmodule

// ----- tb/pileup_base_call_counter_unit_test.sv -----
// ----------------------------------------------------------------------------
// pileup_base_call_counter_unit_test
// Drives call bytes of pileup sites and min_quality writes into the counter
// unit: a directed opening over every class and mark, a site at a high
// threshold, then random sites under several quality thresholds with bursty
// input, patterned output stalls and one long output hold-off. The checker
// beside the block predicts and compares the site counts; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module pileup_base_call_counter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pbcc_pkg::*;

	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_ITEMS    = 180;
	localparam longint TIMEOUT_NS = 2_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MINQ_WIDTH-1:0] cfg_data;
	logic                  call_valid;
	logic                  call_ready;
	pbcc_call_t            call;
	logic                  count_valid;
	logic                  count_ready;
	pbcc_counts_t          counts;
	int unsigned           mismatch_count;
	int unsigned           sites_due;

	// Idling controls of the sender and the receiver, and the current threshold
	bit                    gaps_on;
	bit                    rx_patterned;
	bit                    holdoff_req;
	int unsigned           burst_left;
	logic [MINQ_WIDTH-1:0] cur_min_quality;

	pileup_base_call_counter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.call_valid  (call_valid),
		.call_ready  (call_ready),
		.call        (call),
		.count_valid (count_valid),
		.count_ready (count_ready),
		.counts      (counts)
	);

	pileup_base_call_counter_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.call_valid     (call_valid),
		.call_ready     (call_ready),
		.call           (call),
		.count_valid    (count_valid),
		.count_ready    (count_ready),
		.counts         (counts),
		.mismatch_count (mismatch_count),
		.sites_due      (sites_due)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Count receiver: stall a random leading part of each slot, hold off on request
	initial begin
		int unsigned slot;
		int unsigned stall_len;
		count_ready = 1'b0;
		slot = 0;
		stall_len = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				count_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			if (slot == 0)
				stall_len = rx_patterned ? $urandom_range(0, 12) : 0;
			count_ready <= (slot >= stall_len);
			slot = (slot + 1) % 16;
		end
	end

	// Offer one call byte and hold it until the transfer; idle between bursts
	task automatic send_call(input pbcc_call_t b);
		if (gaps_on && burst_left == 0) begin
			call_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		call_valid <= 1'b1;
		call <= b;
		do @(posedge clk); while (!call_ready);
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic [7:0] q,
			input logic [2:0] ref_code, input logic last);
		pbcc_call_t b;
		b.call_char = c;
		b.qual_char = q;
		b.ref_base  = ref_code;
		b.site_last = last;
		send_call(b);
	endtask

	// Stop offering and wait until every site has been handed out
	task automatic settle_idle();
		call_valid <= 1'b0;
		do @(negedge clk); while (sites_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_quality(input logic [MINQ_WIDTH-1:0] v);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_min_quality = v;
	endtask

	function automatic logic [7:0] class_char(input int unsigned k);
		case (k)
			0:       return CH_FWD_A;
			1:       return CH_FWD_C;
			2:       return CH_FWD_G;
			3:       return CH_FWD_T;
			4:       return CH_FWD_N;
			6:       return CH_REV_A;
			7:       return CH_REV_C;
			8:       return CH_REV_G;
			9:       return CH_REV_T;
			10:      return CH_REV_N;
			default: return CH_DELETION;
		endcase
	endfunction

	// Mostly base calls and reference marks, some read marks and stray bytes
	function automatic logic [7:0] pick_call();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 55)
			return class_char($urandom_range(0, 10));
		if (w < 80)
			return ($urandom_range(0, 1) != 0) ? CH_FWD_REF : CH_REV_REF;
		if (w < 88)
			return CH_READ_BEG;
		if (w < 94)
			return CH_READ_END;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly close around the threshold, otherwise anywhere
	function automatic logic [7:0] pick_qual();
		int q;
		if ($urandom_range(0, 9) < 7) begin
			q = 33 + int'(cur_min_quality) + int'($urandom_range(0, 6)) - 3;
			return 8'(q);
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// One site: well-formed calls at one reference, or pure noise
	task automatic send_site(input int len, input bit noisy);
		pbcc_call_t b;
		logic [2:0] site_ref;
		bit         after_beg;
		site_ref = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
			: 3'($urandom_range(5, 7));
		after_beg = 1'b0;
		for (int k = 0; k < len; k++) begin
			if (noisy) begin
				b.call_char = 8'($urandom_range(0, 255));
				b.qual_char = 8'($urandom_range(0, 255));
				b.ref_base  = 3'($urandom_range(0, 7));
			end else begin
				b.call_char = after_beg ? 8'($urandom_range(0, 255)) : pick_call();
				b.qual_char = pick_qual();
				b.ref_base  = site_ref;
			end
			after_beg = !after_beg && b.call_char == CH_READ_BEG;
			b.site_last = (k == len - 1) || (noisy && $urandom_range(0, 7) == 0);
			send_call(b);
		end
	endtask

	task automatic run_sites(input int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_site(len, $urandom_range(0, 9) == 0);
			sent += len;
		end
	endtask

	// Stimulus
	initial begin
		logic [MINQ_WIDTH-1:0] q;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		call_valid = 1'b0;
		call = '0;
		gaps_on = 1'b1;
		rx_patterned = 1'b1;
		holdoff_req = 1'b0;
		burst_left = 0;
		cur_min_quality = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Every class once, reference A
		send_byte(CH_FWD_A, "I", 3'd0, 1'b0);
		send_byte(CH_FWD_C, "I", 3'd0, 1'b0);
		send_byte(CH_FWD_G, "I", 3'd0, 1'b0);
		send_byte(CH_FWD_T, "I", 3'd0, 1'b0);
		send_byte(CH_FWD_N, "I", 3'd0, 1'b0);
		send_byte(CH_DELETION, "I", 3'd0, 1'b0);
		send_byte(CH_REV_A, "I", 3'd0, 1'b0);
		send_byte(CH_REV_C, "I", 3'd0, 1'b0);
		send_byte(CH_REV_G, "I", 3'd0, 1'b0);
		send_byte(CH_REV_T, "I", 3'd0, 1'b0);
		send_byte(CH_REV_N, "I", 3'd0, 1'b1);

		// Reference marks, read start with a read-start byte as its mapping
		// quality, read end, stray byte, low and extreme qualities, read start
		// on the site's last byte
		send_byte(CH_FWD_REF, "I", 3'd2, 1'b0);
		send_byte(CH_REV_REF, "I", 3'd2, 1'b0);
		send_byte(CH_READ_BEG, "I", 3'd2, 1'b0);
		send_byte(CH_READ_BEG, "I", 3'd2, 1'b0);
		send_byte(CH_FWD_C, "I", 3'd2, 1'b0);
		send_byte(CH_READ_END, "I", 3'd2, 1'b0);
		send_byte("x", "I", 3'd2, 1'b0);
		send_byte(CH_FWD_A, 8'd32, 3'd2, 1'b0);
		send_byte(CH_FWD_A, 8'd0, 3'd2, 1'b0);
		send_byte(CH_FWD_T, 8'd255, 3'd2, 1'b0);
		send_byte(CH_READ_BEG, "I", 3'd2, 1'b1);

		// Nothing carried over; other references make the marks count nothing
		send_byte(CH_FWD_A, 8'd33, 3'd5, 1'b0);
		send_byte(CH_FWD_REF, "I", 3'd5, 1'b0);
		send_byte(CH_REV_REF, "I", 3'd7, 1'b1);

		// A short site at a high threshold: only qualities from 126 up count
		write_min_quality(7'd93);
		gaps_on = 1'b0;
		rx_patterned = 1'b0;
		send_byte(CH_FWD_A, 8'd126, 3'd0, 1'b0);
		send_byte(CH_FWD_A, 8'd127, 3'd0, 1'b0);
		send_byte(CH_FWD_A, 8'd125, 3'd0, 1'b0);
		send_byte(CH_REV_C, 8'd126, 3'd0, 1'b1);

		// Random sites under several thresholds
		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       q = 7'd127;
				1:       q = 7'd0;
				2:       q = 7'd93;
				default: q = 7'($urandom_range(0, 127));
			endcase
			write_min_quality(q);
			gaps_on = (p != 1);
			rx_patterned = (p != 1);
			if (p == 3) begin
				// short sites back to back while the receiver holds off
				holdoff_req = 1'b1;
				gaps_on = 1'b0;
				repeat (80) send_site($urandom_range(1, 2), 1'b0);
				gaps_on = 1'b1;
			end
			run_sites(PHASE_ITEMS);
		end

		settle_idle();
		if (mismatch_count == 0 && sites_due == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
